>>> src/hwfd_pkg.sv
// shared constants, types and size limits for the one-level haar transform
`default_nettype none

package hwfd_pkg;

   // frame limits
   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;

   // field widths
   localparam int PIX_W   = 8;
   localparam int SIZE_W  = 12;
   localparam int LL_W    = 15;
   localparam int BAND_W  = 16;
   localparam int BLOCK_W = 10;

   // counters and line store
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int CMP_W      = ((COL_W > ROW_W) ? COL_W : ROW_W) + 2;
   localparam int HALF_DEPTH = MAX_WIDTH / 2;
   localparam int HALF_AW    = $clog2(HALF_DEPTH);

   // coefficient arithmetic: (combo * 32758 + 512) >> 10
   localparam int COMBO_W    = PIX_W + 4;
   localparam int SCALE_W    = 17;
   localparam int PROD_W     = COMBO_W + SCALE_W;
   localparam int SCALE_NUM  = 32758;
   localparam int FRAC_SHIFT = 10;
   localparam int ROUND_ADD  = 512;

   // size register reset values
   localparam int WIDTH_RESET  = 640;
   localparam int HEIGHT_RESET = 480;

   // csr register map
   localparam int CSR_IDX_W = 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

endpackage

`default_nettype wire

>>> src/hwfd_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none

module hwfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> src/haar_2d_forward_one_level.sv
// top level: raster pixel stream in, one-level 2-d haar subbands out
//
//  channel  dir  handshake            payload
//  req      in   req_valid/req_ready  req_pixel
//  rsp      out  rsp_valid/rsp_ready  rsp_band_ll/lh/hl/hh, rsp_block_col/row, rsp_frame_end
//  csr      in   csr_wr_en            csr_index, csr_wdata (write only, no wait)
//
// one pixel word per cycle sustained while rsp is not stalled; the result of the pixel
// that completes its 2x2 block passes the combine stage, then the scale multipliers
// the line store is two 1024x8 rams, one per column parity, read once per block
// at the odd-row even-column pixel; the registered read is ready for the next pixel
// synchronous reset clears counters and valid flags and loads the default sizes; no clearing pass
// a stall on rsp backs up through the two stages and then drops req_ready
`default_nettype none

module haar_2d_forward_one_level
   import hwfd_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   // pixel input
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [PIX_W-1:0]            req_pixel,
   // subband output
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [LL_W-1:0]                  rsp_band_ll,
   output logic signed [BAND_W-1:0]         rsp_band_lh,
   output logic signed [BAND_W-1:0]         rsp_band_hl,
   output logic signed [BAND_W-1:0]         rsp_band_hh,
   output logic [BLOCK_W-1:0]               rsp_block_col,
   output logic [BLOCK_W-1:0]               rsp_block_row,
   output logic                             rsp_frame_end,
   // configuration
   input  wire logic                        csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]        csr_index,
   input  wire logic [SIZE_W-1:0]           csr_wdata
);

   // drop bit 0, floor at 2, saturate at the even part of the limit
   function automatic logic [SIZE_W-1:0] fit_size(input logic [SIZE_W-1:0] v,
                                                  input int maxv);
      int lim;
      int e;
      lim = maxv & ~1;
      e   = int'(v) & ~1;
      if (e < 2) begin
         e = 2;
      end
      if (e > lim) begin
         e = lim;
      end
      return SIZE_W'(e);
   endfunction

   // (combo * 32758 + 512) >>> 10, floor shift
   function automatic logic [BAND_W-1:0] scale_coef(input logic signed [COMBO_W-1:0] c);
      logic signed [PROD_W-1:0] t;
      t = c * $signed(SCALE_W'(SCALE_NUM)) + $signed(PROD_W'(ROUND_ADD));
      return t[FRAC_SHIFT +: BAND_W];
   endfunction

   // size registers
   logic [SIZE_W-1:0] width_ff, width_in;
   logic [SIZE_W-1:0] height_ff, height_in;

   // raster position and the left pixel of the odd row pair
   logic [COL_W-1:0] col_cnt_ff, col_cnt_in;
   logic [ROW_W-1:0] row_cnt_ff, row_cnt_in;
   logic [PIX_W-1:0] prev_odd_ff, prev_odd_in;

   // combine stage
   logic                      s1_valid_ff, s1_valid_in;
   logic signed [COMBO_W-1:0] s1_ll_ff, s1_lh_ff, s1_hl_ff, s1_hh_ff;
   logic [BLOCK_W-1:0]        s1_col_ff, s1_row_ff;
   logic                      s1_end_ff;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [LL_W-1:0]          out_ll_ff;
   logic [BAND_W-1:0]        out_lh_ff, out_hl_ff, out_hh_ff;
   logic [BLOCK_W-1:0]       out_col_ff, out_row_ff;
   logic                     out_end_ff;

   logic accept;
   logic out_adv;
   logic produce;

   logic [CMP_W-1:0] width_x, height_x;
   logic             col_wrap;
   logic [COL_W-1:0] col_cur;
   logic [CMP_W-1:0] row_pre;
   logic [ROW_W-1:0] row_cur;
   logic [CMP_W-1:0] col_step;
   logic [CMP_W-1:0] row_step;
   logic             frame_end;

   logic [HALF_AW-1:0] pair_addr;
   logic               even_wr, odd_wr, pair_rd;
   logic [PIX_W-1:0]   even_rd_data, odd_rd_data;

   logic signed [COMBO_W-1:0] p00, p01, p10, p11;
   logic signed [COMBO_W-1:0] sum_left, sum_right, dif_left, dif_right;

   logic [BAND_W-1:0] ll_scaled;

   // handshake: output register frees on take, combine stage frees into it
   assign out_adv   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || out_adv;
   assign accept    = req_valid && req_ready;

   // position of this pixel, with wrap for a size that shrank while idle
   always_comb begin
      width_x  = CMP_W'(width_ff);
      height_x = CMP_W'(height_ff);
      col_wrap = CMP_W'(col_cnt_ff) >= width_x;
      col_cur  = col_wrap ? '0 : col_cnt_ff;
      row_pre  = col_wrap ? CMP_W'(row_cnt_ff) + CMP_W'(1) : CMP_W'(row_cnt_ff);
      row_cur  = (row_pre >= height_x) ? '0 : row_pre[ROW_W-1:0];
      col_step = CMP_W'(col_cur) + CMP_W'(1);
      row_step = CMP_W'(row_cur) + CMP_W'(1);
      frame_end = (CMP_W'(row_cur) == height_x - CMP_W'(1)) &&
                  (CMP_W'(col_cur) == width_x - CMP_W'(1));
   end

   // next position after an accepted pixel
   always_comb begin
      col_cnt_in = col_cnt_ff;
      row_cnt_in = row_cnt_ff;
      if (accept) begin
         if (col_step >= width_x) begin
            col_cnt_in = '0;
            row_cnt_in = (row_step >= height_x) ? '0 : row_step[ROW_W-1:0];
         end else begin
            col_cnt_in = col_step[COL_W-1:0];
            row_cnt_in = row_cur;
         end
      end
   end

   // even rows fill the store, odd rows read a column pair at the left pixel
   assign pair_addr = col_cur[COL_W-1:1];
   assign even_wr   = accept && !row_cur[0] && !col_cur[0];
   assign odd_wr    = accept && !row_cur[0] &&  col_cur[0];
   assign pair_rd   = accept &&  row_cur[0] && !col_cur[0];
   assign produce   = accept &&  row_cur[0] &&  col_cur[0];

   assign prev_odd_in = pair_rd ? req_pixel : prev_odd_ff;

   hwfd_ram #(
      .WIDTH (PIX_W),
      .DEPTH (HALF_DEPTH)
   ) u_even_col_ram (
      .clock   (clock),
      .wr_en   (even_wr),
      .wr_addr (pair_addr),
      .wr_data (req_pixel),
      .rd_en   (pair_rd),
      .rd_addr (pair_addr),
      .rd_data (even_rd_data)
   );

   hwfd_ram #(
      .WIDTH (PIX_W),
      .DEPTH (HALF_DEPTH)
   ) u_odd_col_ram (
      .clock   (clock),
      .wr_en   (odd_wr),
      .wr_addr (pair_addr),
      .wr_data (req_pixel),
      .rd_en   (pair_rd),
      .rd_addr (pair_addr),
      .rd_data (odd_rd_data)
   );

   // 2x2 block combos
   always_comb begin
      p00       = $signed(COMBO_W'(even_rd_data));
      p01       = $signed(COMBO_W'(odd_rd_data));
      p10       = $signed(COMBO_W'(prev_odd_ff));
      p11       = $signed(COMBO_W'(req_pixel));
      sum_left  = p00 + p10;
      sum_right = p01 + p11;
      dif_left  = p00 - p10;
      dif_right = p01 - p11;
   end

   assign s1_valid_in  = produce || (s1_valid_ff && !out_adv);
   assign rsp_valid_in = s1_valid_ff || (rsp_valid_ff && !rsp_ready);

   // size register writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:  width_in  = fit_size(csr_wdata, MAX_WIDTH);
            CSR_IMAGE_HEIGHT: height_in = fit_size(csr_wdata, MAX_HEIGHT);
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= fit_size(SIZE_W'(WIDTH_RESET), MAX_WIDTH);
         height_ff    <= fit_size(SIZE_W'(HEIGHT_RESET), MAX_HEIGHT);
         col_cnt_ff   <= '0;
         row_cnt_ff   <= '0;
         prev_odd_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_cnt_ff   <= col_cnt_in;
         row_cnt_ff   <= row_cnt_in;
         prev_odd_ff  <= prev_odd_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // combine stage payload
   always_ff @(posedge clock) begin
      if (produce) begin
         s1_ll_ff  <= sum_left + sum_right;
         s1_lh_ff  <= sum_left - sum_right;
         s1_hl_ff  <= dif_left + dif_right;
         s1_hh_ff  <= dif_left - dif_right;
         s1_col_ff <= BLOCK_W'(col_cur >> 1);
         s1_row_ff <= BLOCK_W'(row_cur >> 1);
         s1_end_ff <= frame_end;
      end
   end

   // scale stage: four constant multipliers into the output register
   assign ll_scaled = scale_coef(s1_ll_ff);

   always_ff @(posedge clock) begin
      if (s1_valid_ff && out_adv) begin
         out_ll_ff  <= ll_scaled[LL_W-1:0];
         out_lh_ff  <= scale_coef(s1_lh_ff);
         out_hl_ff  <= scale_coef(s1_hl_ff);
         out_hh_ff  <= scale_coef(s1_hh_ff);
         out_col_ff <= s1_col_ff;
         out_row_ff <= s1_row_ff;
         out_end_ff <= s1_end_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_band_ll   = out_ll_ff;
   assign rsp_band_lh   = $signed(out_lh_ff);
   assign rsp_band_hl   = $signed(out_hl_ff);
   assign rsp_band_hh   = $signed(out_hh_ff);
   assign rsp_block_col = out_col_ff;
   assign rsp_block_row = out_row_ff;
   assign rsp_frame_end = out_end_ff;

endmodule

`default_nettype wire

>>> src/hwfd_checker.sv
// port-level checks for the haar transform top level, bound to it
`default_nettype none

module hwfd_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic [7:0]         req_pixel,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [14:0]        rsp_band_ll,
   input wire logic signed [15:0] rsp_band_lh,
   input wire logic signed [15:0] rsp_band_hl,
   input wire logic signed [15:0] rsp_band_hh,
   input wire logic [9:0]         rsp_block_col,
   input wire logic [9:0]         rsp_block_row,
   input wire logic               rsp_frame_end,
   input wire logic               csr_wr_en,
   input wire logic [0:0]         csr_index,
   input wire logic [11:0]        csr_wdata
);

   // reset empties the output register
   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a held word keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_band_ll) &&
         $stable(rsp_band_lh) && $stable(rsp_band_hl) && $stable(rsp_band_hh) &&
         $stable(rsp_block_col) && $stable(rsp_block_row) && $stable(rsp_frame_end))
      else $error("rsp word changed while stalled");

   // input backs up only behind a stalled output word
   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("req_ready low without an output stall");

   // coefficient ranges of 8-bit pixels
   a_band_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_band_ll <= 15'd32630 &&
         rsp_band_lh <= 16'sd16315 && rsp_band_lh >= -16'sd16315 &&
         rsp_band_hl <= 16'sd16315 && rsp_band_hl >= -16'sd16315 &&
         rsp_band_hh <= 16'sd16315 && rsp_band_hh >= -16'sd16315)
      else $error("subband coefficient out of range");

endmodule

bind haar_2d_forward_one_level hwfd_checker u_hwfd_checker (.*);

`default_nettype wire

>>> tb/tb_haar_2d_forward_one_level.sv
`timescale 1ns / 1ps
// self-checking testbench for the one-level 2-d haar forward transform
module tb_haar_2d_forward_one_level;
   import hwfd_pkg::*;

   // stimulus sizing and timing knobs
   localparam int RANDOM_WORDS = 580;      // pixel words in the random part
   localparam int WIDE_WORDS   = 256;      // part of the first row at full width
   localparam int TALL_WORDS   = 256;      // top of the tall thin frame
   localparam int LONG_HOLD    = 200;      // cycles of a long output stall
   localparam int PIPE_SLACK   = 8;        // two-stage pipe plus margin
   localparam int LIMIT_NS     = 3_000_000;

   // one subband word as it leaves the block
   typedef struct packed {
      logic [LL_W-1:0]    ll;
      logic [BAND_W-1:0]  lh;
      logic [BAND_W-1:0]  hl;
      logic [BAND_W-1:0]  hh;
      logic [BLOCK_W-1:0] col;
      logic [BLOCK_W-1:0] row;
      logic               fe;
   } subband_type;

   // directed row: pixel, and a typed expectation where one is obvious
   typedef struct {
      logic [PIX_W-1:0] px;
      bit               typed;
      subband_type      want;
   } pattern_row_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [PIX_W-1:0]         req_pixel;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [LL_W-1:0]          rsp_band_ll;
   logic signed [BAND_W-1:0] rsp_band_lh;
   logic signed [BAND_W-1:0] rsp_band_hl;
   logic signed [BAND_W-1:0] rsp_band_hh;
   logic [BLOCK_W-1:0]       rsp_block_col;
   logic [BLOCK_W-1:0]       rsp_block_row;
   logic                     rsp_frame_end;
   logic                     csr_wr_en;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [SIZE_W-1:0]        csr_wdata;

   haar_2d_forward_one_level dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_pixel     (req_pixel),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_band_ll   (rsp_band_ll),
      .rsp_band_lh   (rsp_band_lh),
      .rsp_band_hl   (rsp_band_hl),
      .rsp_band_hh   (rsp_band_hh),
      .rsp_block_col (rsp_block_col),
      .rsp_block_row (rsp_block_row),
      .rsp_frame_end (rsp_frame_end),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   // transform state mirrored in the testbench
   logic [PIX_W-1:0] line_mem [MAX_WIDTH];   // even-row pixels by column
   logic [PIX_W-1:0] left_odd_px;            // odd-row pixel of the even column
   int unsigned      col_pos;
   int unsigned      row_pos;
   int unsigned      eff_width;
   int unsigned      eff_height;

   // subband words predicted but not yet seen at the output
   subband_type      pending_blocks [$];

   pattern_row_type  pattern_rows [24];

   int mismatches;
   int pixels_in;
   int blocks_out;
   int frame_ends;
   int size_writes;

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #(LIMIT_NS);
      $display("run timed out with %0d subband words outstanding", pending_blocks.size());
      $display("tb_haar_2d_forward_one_level: FAIL");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("mismatch at %0t: %s", $time, msg);
   endtask

   // size register as the block sees it: bit 0 dropped, at least 2, at most the limit
   function automatic int unsigned clamp_size(input logic [SIZE_W-1:0] raw,
                                              input int unsigned lim);
      int unsigned e;
      e = {raw[SIZE_W-1:1], 1'b0};
      if (e < 2)
         e = 2;
      if (e > (lim & 32'hFFFF_FFFE))
         e = lim & 32'hFFFF_FFFE;
      return e;
   endfunction

   // (combo * 32758 + 512) >> 10 with a flooring shift
   function automatic longint scale_band(input int combo);
      longint t;
      t = longint'(combo) * SCALE_NUM + ROUND_ADD;
      return t >>> FRAC_SHIFT;
   endfunction

   function automatic logic [PIX_W-1:0] rand_pixel();
      int unsigned r;
      r = $urandom_range(0, 9);
      // lean on the range ends now and then
      if (r == 0)
         return '0;
      if (r == 1)
         return '1;
      return PIX_W'($urandom_range(0, 255));
   endfunction

   // advance the raster position by one pixel, form the block when it closes
   task automatic predict_block(input logic [PIX_W-1:0] px, output bit made,
                                output subband_type blk);
      int unsigned c;
      int unsigned r;
      int          p00;
      int          p01;
      int          p10;
      int          p11;
      made = 1'b0;
      blk  = '0;
      // a size shrunk under a running frame wraps before the pixel lands
      if (col_pos >= eff_width) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= eff_height)
         row_pos = 0;
      c = col_pos;
      r = row_pos;
      if (!r[0]) begin
         line_mem[c % MAX_WIDTH] = px;
      end else if (!c[0]) begin
         left_odd_px = px;
      end else begin
         p00      = line_mem[(c - 1) % MAX_WIDTH];
         p01      = line_mem[c % MAX_WIDTH];
         p10      = left_odd_px;
         p11      = px;
         blk.ll   = LL_W'(scale_band(p00 + p10 + p01 + p11));
         blk.lh   = BAND_W'(scale_band((p00 + p10) - (p01 + p11)));
         blk.hl   = BAND_W'(scale_band((p00 - p10) + (p01 - p11)));
         blk.hh   = BAND_W'(scale_band((p00 - p10) - (p01 - p11)));
         blk.col  = BLOCK_W'(c >> 1);
         blk.row  = BLOCK_W'(r >> 1);
         blk.fe   = (r == eff_height - 1) && (c == eff_width - 1);
         made     = 1'b1;
      end
      col_pos = c + 1;
      if (col_pos >= eff_width) begin
         col_pos = 0;
         row_pos = r + 1;
         if (row_pos >= eff_height)
            row_pos = 0;
      end
   endtask

   // offer one pixel word, wait for the handshake, then log its expectation
   task automatic feed_word(input logic [PIX_W-1:0] px, input bit typed,
                            input subband_type want);
      bit          made;
      subband_type blk;
      // random gaps on the input, none inside the quiet window
      while (!(pixels_in >= 150 && pixels_in < 450) && $urandom_range(0, 99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= px;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      pixels_in++;
      predict_block(px, made, blk);
      if (made)
         pending_blocks.insert(pending_blocks.size(), typed ? want : blk);
   endtask

   // stop offering until every expected word is out and the pipe is empty
   task automatic drain_blocks();
      req_valid <= 1'b0;
      while (pending_blocks.size() != 0)
         @(posedge clock);
      repeat (PIPE_SLACK) @(posedge clock);
   endtask

   // write the size registers, only ever called with the block idle
   task automatic write_sizes(input bit do_w, input logic [SIZE_W-1:0] w_raw,
                              input bit do_h, input logic [SIZE_W-1:0] h_raw);
      if (do_w) begin
         csr_wr_en <= 1'b1;
         csr_index <= CSR_IMAGE_WIDTH;
         csr_wdata <= w_raw;
         @(posedge clock);
         eff_width = clamp_size(w_raw, MAX_WIDTH);
         size_writes++;
      end
      if (do_h) begin
         csr_wr_en <= 1'b1;
         csr_index <= CSR_IMAGE_HEIGHT;
         csr_wdata <= h_raw;
         @(posedge clock);
         eff_height = clamp_size(h_raw, MAX_HEIGHT);
         size_writes++;
      end
      csr_wr_en <= 1'b0;
   endtask

   // field-by-field compare against the oldest expectation
   task automatic check_block(input subband_type got);
      subband_type want;
      if (pending_blocks.size() == 0) begin
         report_mismatch($sformatf("subband word with nothing expected (col %0d row %0d)",
                                   got.col, got.row));
         return;
      end
      want = pending_blocks.pop_front();
      if (got.ll !== want.ll)
         report_mismatch($sformatf("band_ll got %0d expected %0d", got.ll, want.ll));
      if (got.lh !== want.lh)
         report_mismatch($sformatf("band_lh got %0d expected %0d",
                                   $signed(got.lh), $signed(want.lh)));
      if (got.hl !== want.hl)
         report_mismatch($sformatf("band_hl got %0d expected %0d",
                                   $signed(got.hl), $signed(want.hl)));
      if (got.hh !== want.hh)
         report_mismatch($sformatf("band_hh got %0d expected %0d",
                                   $signed(got.hh), $signed(want.hh)));
      if (got.col !== want.col)
         report_mismatch($sformatf("block_col got %0d expected %0d", got.col, want.col));
      if (got.row !== want.row)
         report_mismatch($sformatf("block_row got %0d expected %0d", got.row, want.row));
      if (got.fe !== want.fe)
         report_mismatch($sformatf("frame_end got %0b expected %0b at col %0d row %0d",
                                   got.fe, want.fe, want.col, want.row));
   endtask

   // output side: sample accepted words, then pick the next ready
   initial begin
      subband_type got;
      int          hold_left;
      int          holds_done;
      hold_left  = 0;
      holds_done = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_valid && rsp_ready) begin
               got = '{rsp_band_ll, rsp_band_lh, rsp_band_hl, rsp_band_hh,
                       rsp_block_col, rsp_block_row, rsp_frame_end};
               check_block(got);
               blocks_out++;
               if (rsp_frame_end)
                  frame_ends++;
            end
            if (hold_left > 0) begin
               rsp_ready <= 1'b0;
               hold_left--;
            end else if ((holds_done == 0 && blocks_out >= 20) ||
                         (holds_done == 1 && blocks_out >= 120)) begin
               // long stall while the input keeps coming: pipe fills, req_ready drops
               holds_done++;
               hold_left = LONG_HOLD - 1;
               rsp_ready <= 1'b0;
            end else if (blocks_out >= 40 && blocks_out < 110) begin
               // stretch with the output always ready
               rsp_ready <= 1'b1;
            end else begin
               rsp_ready <= ($urandom_range(0, 99) >= 7);
            end
         end
      end
   end

   // stimulus
   initial begin
      int                unsigned n;
      int                unsigned sel;
      int                rand_words;
      bit                do_w;
      bit                do_h;
      logic [SIZE_W-1:0] w_raw;
      logic [SIZE_W-1:0] h_raw;

      // every input known from time zero
      reset     = 1'b1;
      req_valid = 1'b0;
      req_pixel = '0;
      csr_wr_en = 1'b0;
      csr_index = CSR_IMAGE_WIDTH;
      csr_wdata = '0;

      // state after reset
      col_pos     = 0;
      row_pos     = 0;
      left_odd_px = '0;
      eff_width   = WIDTH_RESET;
      eff_height  = HEIGHT_RESET;
      mismatches  = 0;
      pixels_in   = 0;
      blocks_out  = 0;
      frame_ends  = 0;
      size_writes = 0;
      rand_words  = 0;

      // 2x2 frames, raster order p00 p01 p10 p11, so every fourth word closes a block
      pattern_rows = '{
         // all pixels full scale: largest low-low, details zero
         '{8'd255, 1'b0, '0}, '{8'd255, 1'b0, '0}, '{8'd255, 1'b0, '0},
         '{8'd255, 1'b1, '{15'd32630, 16'sd0, 16'sd0, 16'sd0, 10'd0, 10'd0, 1'b1}},
         // all zero: rounding constant alone floors to zero
         '{8'd0, 1'b0, '0}, '{8'd0, 1'b0, '0}, '{8'd0, 1'b0, '0},
         '{8'd0, 1'b1, '{15'd0, 16'sd0, 16'sd0, 16'sd0, 10'd0, 10'd0, 1'b1}},
         // bright left column: largest positive lh
         '{8'd255, 1'b0, '0}, '{8'd0, 1'b0, '0}, '{8'd255, 1'b0, '0},
         '{8'd0, 1'b1, '{15'd16315, 16'sd16315, 16'sd0, 16'sd0, 10'd0, 10'd0, 1'b1}},
         // bright right column: most negative lh, floor rounding below zero
         '{8'd0, 1'b0, '0}, '{8'd255, 1'b0, '0}, '{8'd0, 1'b0, '0},
         '{8'd255, 1'b1, '{15'd16315, -16'sd16315, 16'sd0, 16'sd0, 10'd0, 10'd0, 1'b1}},
         // bright top row: largest positive hl
         '{8'd255, 1'b0, '0}, '{8'd255, 1'b0, '0}, '{8'd0, 1'b0, '0},
         '{8'd0, 1'b1, '{15'd16315, 16'sd0, 16'sd16315, 16'sd0, 10'd0, 10'd0, 1'b1}},
         // mixed block, left to the mirrored transform
         '{8'd200, 1'b0, '0}, '{8'd3, 1'b0, '0}, '{8'd17, 1'b0, '0},
         '{8'd255, 1'b0, '0}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // odd register values fold down to a 2x2 frame
      write_sizes(1'b1, SIZE_W'(3), 1'b1, SIZE_W'(3));
      foreach (pattern_rows[i])
         feed_word(pattern_rows[i].px, pattern_rows[i].typed, pattern_rows[i].want);
      drain_blocks();

      // oversize width saturates to the full line: a long first row, no block closes
      write_sizes(1'b1, '1, 1'b1, SIZE_W'(1));
      repeat (WIDE_WORDS) feed_word(rand_pixel(), 1'b0, '0);
      drain_blocks();

      // zero width becomes 2, oversize height saturates: a tall thin frame
      write_sizes(1'b1, '0, 1'b1, '1);
      repeat (TALL_WORDS) feed_word(rand_pixel(), 1'b0, '0);
      drain_blocks();

      // random phases: mostly small frames, phase ends land mid-frame
      while (rand_words < RANDOM_WORDS) begin
         sel   = $urandom_range(0, 99);
         w_raw = (sel < 80) ? SIZE_W'($urandom_range(0, 24)) :
                 (sel < 95) ? SIZE_W'($urandom_range(25, 130)) :
                              SIZE_W'($urandom_range(2040, 4095));
         sel   = $urandom_range(0, 99);
         h_raw = (sel < 85) ? SIZE_W'($urandom_range(0, 10)) :
                 (sel < 95) ? SIZE_W'($urandom_range(11, 64)) :
                              SIZE_W'($urandom_range(2040, 4095));
         sel   = $urandom_range(0, 3);
         do_w  = (sel != 3);
         do_h  = (sel != 2);
         // widening during an odd row would pair pixels with columns never stored
         if (do_w && clamp_size(w_raw, MAX_WIDTH) > eff_width && row_pos[0])
            w_raw = SIZE_W'(eff_width);
         write_sizes(do_w, w_raw, do_h, h_raw);
         n = $urandom_range(16, 160);
         repeat (n) feed_word(rand_pixel(), 1'b0, '0);
         rand_words += n;
         drain_blocks();
      end

      $display("covered %0d pixel words, %0d subband words with %0d frame ends, %0d size writes",
               pixels_in, blocks_out, frame_ends, size_writes);
      $display("2x2 frames, full-width and full-height registers, sizes changed mid-frame");
      if (mismatches == 0)
         $display("tb_haar_2d_forward_one_level: PASS");
      else
         $display("tb_haar_2d_forward_one_level: FAIL");
      $finish;
   end

endmodule

>>> haar_2d_forward_one_level.f
src/hwfd_pkg.sv
src/hwfd_ram.sv
src/haar_2d_forward_one_level.sv
src/hwfd_checker.sv
tb/tb_haar_2d_forward_one_level.sv
